[hw/rtl/u8enc_pkg.sv]
// Shared types, constants and helper functions for the UTF-8 encoder.
// No dependencies; every other file of the encoder imports this package.
package u8enc_pkg;

    localparam int unsigned UnitWidth = 32;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CountWidth = 3;
    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [15:0] SurrogateLow = 16'hD800;
    localparam logic [15:0] SurrogateHigh = 16'hDFFF;
    localparam logic [10:0] PlaneOffset = 11'h040;

    typedef logic [ByteWidth-1:0] t_lead_table [8];
    localparam t_lead_table LeadMark = '{
        8'h00, 8'h00, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE
    };

    typedef struct packed {
        logic [UnitWidth-1:0]  code_point;
        logic [CountWidth-1:0] n_bytes;
    } t_job;

    function automatic logic [CountWidth-1:0] byte_count(input logic [UnitWidth-1:0] cp);
        logic [CountWidth-1:0] n;
        if (cp < 32'h0000_0080) begin
            n = 3'd1;
        end else if (cp < 32'h0000_0800) begin
            n = 3'd2;
        end else if (cp < 32'h0001_0000) begin
            n = 3'd3;
        end else if (cp < 32'h0020_0000) begin
            n = 3'd4;
        end else if (cp < 32'h0400_0000) begin
            n = 3'd5;
        end else if (cp < 32'h8000_0000) begin
            n = 3'd6;
        end else begin
            n = 3'd7;
        end
        return n;
    endfunction

    function automatic logic [ByteWidth-1:0] encode_byte(
        input logic [UnitWidth-1:0]  cp,
        input logic [CountWidth-1:0] n,
        input logic [CountWidth-1:0] idx
    );
        logic [47:0]           ext;
        logic [CountWidth-1:0] k;
        logic [ByteWidth-1:0]  seg;
        logic [ByteWidth-1:0]  res;
        ext = {16'h0000, cp};
        k = n - idx - 3'd1;
        case (k)
            3'd0:    seg = ext[7:0];
            3'd1:    seg = ext[13:6];
            3'd2:    seg = ext[19:12];
            3'd3:    seg = ext[25:18];
            3'd4:    seg = ext[31:24];
            3'd5:    seg = ext[37:30];
            3'd6:    seg = ext[43:36];
            default: seg = '0;
        endcase
        if (idx == '0) begin
            res = seg | LeadMark[n];
        end else begin
            res = {2'b10, seg[5:0]};
        end
        return res;
    endfunction

endpackage

[hw/rtl/u8enc_unit_if.sv]
// Input channel of the UTF-8 encoder: one code unit per word.
// Depends on u8enc_pkg for the field widths.
interface u8enc_unit_if import u8enc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [UnitWidth-1:0] code_unit;
    logic                 unit_is_final;

    modport source (output valid, output code_unit, output unit_is_final, input ready);
    modport sink (input valid, input code_unit, input unit_is_final, output ready);
endinterface

[hw/rtl/u8enc_byte_if.sv]
// Output channel of the UTF-8 encoder: one encoded byte per word.
// Depends on u8enc_pkg for the field widths.
interface u8enc_byte_if import u8enc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] utf8_byte;
    logic                 ends_code_point;

    modport source (output valid, output utf8_byte, output ends_code_point, input ready);
    modport sink (input valid, input utf8_byte, input ends_code_point, output ready);
endinterface

[hw/rtl/utf16_utf32_to_utf8_encoder.sv]
// Top level of the UTF-16 / UTF-32 to UTF-8 encoder.
// Depends on u8enc_pkg, the two channel interfaces and the front, queue and back.
//
// Input channel i_unit takes one code unit per word (valid/ready). In UTF-16
// mode a surrogate is held and joined with the next unit, or dropped if final;
// in UTF-32 mode each unit is a code point. The output channel o_byte gives one
// UTF-8 byte per word, lead byte first, with ends_code_point set on the last
// byte. The user must write the mode register through i_cfg_we and i_cfg_wdata
// only while idle; the block does not enforce it. The job queue between the
// front and back ends holds jobs until their bytes go into the output register,
// and lets new units enter while earlier bytes still wait. The block takes one
// unit per cycle while code points are single bytes and the receiver takes each
// byte; a code point of n bytes holds the back end for all n bytes, made one per
// cycle when not stalled into a single output register. When the receiver
// stalls, the output word holds and the queue fills; the input ready falls only
// when the queue is full. Reset clears the mode to UTF-16, drops any held
// surrogate and empties the queue and output register.
module utf16_utf32_to_utf8_encoder import u8enc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    u8enc_unit_if.sink   i_unit,
    u8enc_byte_if.source o_byte
);

    logic queue_full;
    logic queue_nonempty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    u8enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_unit       (i_unit),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    u8enc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_nonempty (queue_nonempty),
        .o_head     (head_job)
    );

    u8enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (queue_nonempty),
        .i_head     (head_job),
        .o_pop      (pop),
        .o_byte     (o_byte)
    );

endmodule

[hw/rtl/u8enc_front.sv]
// Front end: holds the mode register and the surrogate state, turns the
// accepted units into code point jobs. Depends on u8enc_pkg and u8enc_unit_if.
module u8enc_front import u8enc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    u8enc_unit_if.sink      i_unit,
    input  logic            i_queue_full,
    output logic            o_push,
    output t_job            o_job
);

    logic       r_input_mode;
    logic       r_pending;
    logic [9:0] r_held;
    logic       n_pending;
    logic [9:0] n_held;
    logic       accept;
    logic       emit;
    logic [15:0] unit16;
    logic [UnitWidth-1:0] cp;
    logic [10:0] high_part;

    assign i_unit.ready = !i_queue_full;
    assign accept = i_unit.valid && i_unit.ready;
    assign unit16 = i_unit.code_unit[15:0];
    assign high_part = {1'b0, r_held} + PlaneOffset;

    always_comb begin
        n_pending = r_pending;
        n_held = r_held;
        emit = 1'b0;
        cp = i_unit.code_unit;
        if (r_input_mode) begin
            n_pending = 1'b0;
            n_held = '0;
            emit = 1'b1;
        end else if (r_pending) begin
            cp = {11'h000, high_part, unit16[9:0]};
            n_pending = 1'b0;
            n_held = '0;
            emit = 1'b1;
        end else if (unit16 < SurrogateLow || unit16 > SurrogateHigh) begin
            cp = {16'h0000, unit16};
            emit = 1'b1;
        end else if (i_unit.unit_is_final) begin
            n_held = '0;
        end else begin
            n_pending = 1'b1;
            n_held = unit16[9:0];
        end
    end

    assign o_push = accept && emit;
    assign o_job.code_point = cp;
    assign o_job.n_bytes = byte_count(cp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_mode <= 1'b0;
            r_pending <= 1'b0;
            r_held <= '0;
        end else begin
            if (i_cfg_we) begin
                r_input_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_pending <= n_pending;
                r_held <= n_held;
            end
        end
    end

endmodule

[hw/rtl/u8enc_queue.sv]
// Small register queue of code point jobs between the front and back ends.
// Depends on u8enc_pkg for the job type.
module u8enc_queue import u8enc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_head
);

    localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QUEUE_DEPTH - 1);

    t_job                r_mem [QUEUE_DEPTH];
    logic [PtrWidth-1:0] r_wr_ptr;
    logic [PtrWidth-1:0] r_rd_ptr;
    logic [CntWidth-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full = r_count == CntWidth'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_head = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/u8enc_back.sv]
// Back end: walks the head job byte by byte into a registered output word.
// Depends on u8enc_pkg and u8enc_byte_if.
module u8enc_back import u8enc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_job        i_head,
    output logic        o_pop,
    u8enc_byte_if.source o_byte
);

    logic [CountWidth-1:0] r_idx;
    logic                  r_valid;
    logic [ByteWidth-1:0]  r_byte;
    logic                  r_last;
    logic                  load;
    logic                  is_last;

    assign load = i_nonempty && (!r_valid || o_byte.ready);
    assign is_last = r_idx == i_head.n_bytes - 3'd1;
    assign o_pop = load && is_last;

    assign o_byte.valid = r_valid;
    assign o_byte.utf8_byte = r_byte;
    assign o_byte.ends_code_point = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= encode_byte(i_head.code_point, i_head.n_bytes, r_idx);
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx <= is_last ? '0 : r_idx + 3'd1;
            end else if (o_byte.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
